/* design/voxel_face_culling_top_assert.svh */
// Assertion macros for the voxel face culling top level.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef VOXEL_FACE_CULLING_TOP_ASSERT_SVH
`define VOXEL_FACE_CULLING_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VFC_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("voxel_face_culling_top: check failed");

// Next-cycle implication, disabled during reset.
`define VFC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("voxel_face_culling_top: check failed");

`endif

/* design/vfc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the voxel face culling block.
// No dependencies; imported by the register file, the core, the top level and the testbench.
package vfc_pkg;

    localparam int DIM_X         = 16;
    localparam int DIM_Y         = 16;
    localparam int DIM_Z         = 16;
    localparam int BLOCK_ID_BITS = 8;

    localparam int CELL_COUNT = DIM_X * DIM_Y * DIM_Z;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    localparam int POS_W  = 4;
    localparam int ID_W   = 8;
    localparam int SIZE_W = 5;
    localparam int FACE_W = 3;
    localparam int MASK_W = 6;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [BLOCK_ID_BITS-1:0] t_bid;
    typedef logic [SIZE_W-1:0]        t_size;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [2:0]               t_dir;
    typedef logic [FACE_W-1:0]        t_face;
    typedef logic [1:0]               t_reg_idx;

    localparam t_addr DIM_X_A  = t_addr'(DIM_X);
    localparam t_addr DIM_Z_A  = t_addr'(DIM_Z);
    localparam t_addr CLR_LAST = t_addr'(CELL_COUNT - 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    localparam t_reg_idx REG_SIZE_X = 2'd0;
    localparam t_reg_idx REG_SIZE_Y = 2'd1;
    localparam t_reg_idx REG_SIZE_Z = 2'd2;

    localparam t_size SIZE_RESET = t_size'(16);

    // neighbor check order
    localparam t_dir DIR_NX = 3'd0;
    localparam t_dir DIR_PX = 3'd1;
    localparam t_dir DIR_NZ = 3'd2;
    localparam t_dir DIR_PZ = 3'd3;
    localparam t_dir DIR_PY = 3'd4;
    localparam t_dir DIR_NY = 3'd5;

    localparam t_face FACE_PY = 3'd0;
    localparam t_face FACE_NY = 3'd1;
    localparam t_face FACE_NX = 3'd2;
    localparam t_face FACE_PX = 3'd3;
    localparam t_face FACE_PZ = 3'd4;
    localparam t_face FACE_NZ = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CENTER,
        ST_NBR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_size ext_x;
        t_size ext_y;
        t_size ext_z;
    } t_cfg;

    typedef struct packed {
        logic  in_grid;
        t_addr addr;
    } t_nbr;

    function automatic t_size ext_of(input t_size size, input int dim);
        return (int'(size) < dim) ? size : t_size'(dim);
    endfunction

    function automatic t_addr cell_index(input t_pos x, input t_pos y, input t_pos z);
        return (t_addr'(y) * DIM_X_A + t_addr'(x)) * DIM_Z_A + t_addr'(z);
    endfunction

    function automatic t_face face_code(input t_dir d);
        t_face f;
        case (d)
            DIR_NX:  f = FACE_NX;
            DIR_PX:  f = FACE_PX;
            DIR_NZ:  f = FACE_NZ;
            DIR_PZ:  f = FACE_PZ;
            DIR_PY:  f = FACE_PY;
            DIR_NY:  f = FACE_NY;
            default: f = FACE_PY;
        endcase
        return f;
    endfunction

    function automatic t_nbr nbr_of(input t_dir d, input t_pos x, input t_pos y,
                                    input t_pos z, input t_cfg ext);
        t_size nx;
        t_size ny;
        t_size nz;
        logic  under;
        t_nbr  r;
        nx    = t_size'(x);
        ny    = t_size'(y);
        nz    = t_size'(z);
        under = 1'b0;
        case (d)
            DIR_NX: begin
                under = (x == '0);
                nx    = nx - t_size'(1);
            end
            DIR_PX: nx = nx + t_size'(1);
            DIR_NZ: begin
                under = (z == '0);
                nz    = nz - t_size'(1);
            end
            DIR_PZ: nz = nz + t_size'(1);
            DIR_PY: ny = ny + t_size'(1);
            DIR_NY: begin
                under = (y == '0);
                ny    = ny - t_size'(1);
            end
            default: under = 1'b1;
        endcase
        r.in_grid = !under && (nx < ext.ext_x) && (ny < ext.ext_y) && (nz < ext.ext_z);
        r.addr    = cell_index(nx[POS_W-1:0], ny[POS_W-1:0], nz[POS_W-1:0]);
        return r;
    endfunction

endpackage

/* design/vfc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command beats and face beats.
// Depends on vfc_pkg for field widths.
interface vfc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [vfc_pkg::POS_W-1:0] pos_x;
    logic [vfc_pkg::POS_W-1:0] pos_y;
    logic [vfc_pkg::POS_W-1:0] pos_z;
    logic [vfc_pkg::ID_W-1:0]  block_id;

    modport source(output valid, op, pos_x, pos_y, pos_z, block_id, input ready);
    modport sink(input valid, op, pos_x, pos_y, pos_z, block_id, output ready);
endinterface

interface vfc_out_if;
    logic                       valid;
    logic                       ready;
    logic [vfc_pkg::POS_W-1:0]  face_x;
    logic [vfc_pkg::POS_W-1:0]  face_y;
    logic [vfc_pkg::POS_W-1:0]  face_z;
    logic [vfc_pkg::FACE_W-1:0] face;
    logic [vfc_pkg::ID_W-1:0]   face_block;
    logic                       last;

    modport source(output valid, face_x, face_y, face_z, face, face_block, last,
                   input ready);
    modport sink(input valid, face_x, face_y, face_z, face, face_block, last,
                 output ready);
endinterface

/* design/vfc_cfg_regs.sv */
`timescale 1ns / 1ps
// APB register file holding the grid extents; outputs the clamped extents in use.
// Depends on vfc_pkg.
module vfc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vfc_pkg::PADDR_W-1:0]   paddr,
    input  logic [vfc_pkg::PDATA_W-1:0]   pwdata,
    output logic [vfc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output vfc_pkg::t_cfg                 o_cfg
);
    import vfc_pkg::*;

    t_size    r_size_x;
    t_size    r_size_y;
    t_size    r_size_z;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SIZE_X: r_size_x <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y: r_size_y <= pwdata[SIZE_W-1:0];
                REG_SIZE_Z: r_size_z <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SIZE_X: prdata = PDATA_W'(r_size_x);
            REG_SIZE_Y: prdata = PDATA_W'(r_size_y);
            REG_SIZE_Z: prdata = PDATA_W'(r_size_z);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.ext_x = ext_of(r_size_x, DIM_X);
    assign o_cfg.ext_y = ext_of(r_size_y, DIM_Y);
    assign o_cfg.ext_z = ext_of(r_size_z, DIM_Z);

endmodule

/* design/vfc_core.sv */
`timescale 1ns / 1ps
// Grid memory with its read-modify sequencer and the face output register.
// Depends on vfc_pkg and the channel interfaces in vfc_if.sv.
module vfc_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vfc_pkg::t_cfg i_cfg,
    vfc_in_if.sink        i_in,
    vfc_out_if.source     o_out
);
    import vfc_pkg::*;

    t_bid r_mem [CELL_COUNT];
    t_bid r_rdata;

    t_state             r_state, n_state;
    t_addr              r_clr_cnt, n_clr_cnt;
    t_pos               r_x, n_x;
    t_pos               r_y, n_y;
    t_pos               r_z, n_z;
    t_bid               r_blk, n_blk;
    t_dir               r_step, n_step;
    logic [MASK_W-1:0]  r_mask, n_mask;
    logic               r_nb_in, n_nb_in;
    logic               r_ovalid, n_ovalid;
    t_pos               r_ox, n_ox;
    t_pos               r_oy, n_oy;
    t_pos               r_oz, n_oz;
    t_face              r_oface, n_oface;
    t_bid               r_oblk, n_oblk;
    logic               r_olast, n_olast;

    logic  mem_we;
    logic  mem_re;
    t_addr mem_addr;
    t_bid  mem_wdata;

    logic  in_inside;
    t_addr in_addr;
    t_nbr  nb;
    t_dir  first;
    logic  out_free;

    assign in_inside = (t_size'(i_in.pos_x) < i_cfg.ext_x)
                    && (t_size'(i_in.pos_y) < i_cfg.ext_y)
                    && (t_size'(i_in.pos_z) < i_cfg.ext_z);
    assign in_addr   = cell_index(i_in.pos_x, i_in.pos_y, i_in.pos_z);
    assign out_free  = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        first = DIR_NX;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (r_mask[i]) first = t_dir'(i);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_blk     = r_blk;
        n_step    = r_step;
        n_mask    = r_mask;
        n_nb_in   = r_nb_in;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_oz      = r_oz;
        n_oface   = r_oface;
        n_oblk    = r_oblk;
        n_olast   = r_olast;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_clr_cnt;
        mem_wdata = '0;
        nb        = nbr_of(t_dir'(r_step + 3'd1), r_x, r_y, r_z, i_cfg);
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                n_clr_cnt = r_clr_cnt + t_addr'(1);
                if (r_clr_cnt == CLR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                n_x = i_in.pos_x;
                n_y = i_in.pos_y;
                n_z = i_in.pos_z;
                if (i_in.valid && in_inside) begin
                    mem_addr = in_addr;
                    if (i_in.op == OP_WRITE) begin
                        mem_we    = 1'b1;
                        mem_wdata = t_bid'(i_in.block_id);
                    end else begin
                        mem_re  = 1'b1;
                        n_state = ST_CENTER;
                    end
                end
            end
            ST_CENTER: begin
                nb      = nbr_of(DIR_NX, r_x, r_y, r_z, i_cfg);
                n_blk   = r_rdata;
                n_step  = DIR_NX;
                n_mask  = '0;
                n_nb_in = nb.in_grid;
                if (r_rdata == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    mem_re   = nb.in_grid;
                    mem_addr = nb.addr;
                    n_state  = ST_NBR;
                end
            end
            ST_NBR: begin
                n_mask[r_step] = !r_nb_in || (r_rdata == '0);
                if (r_step == DIR_NY) begin
                    n_state = ST_EMIT;
                end else begin
                    mem_re   = nb.in_grid;
                    mem_addr = nb.addr;
                    n_nb_in  = nb.in_grid;
                    n_step   = t_dir'(r_step + 3'd1);
                end
            end
            ST_EMIT: begin
                if (r_mask == '0) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_mask   = r_mask & ~(MASK_W'(1) << first);
                    n_ovalid = 1'b1;
                    n_ox     = r_x;
                    n_oy     = r_y;
                    n_oz     = r_z;
                    n_oface  = face_code(first);
                    n_oblk   = r_blk;
                    n_olast  = (n_mask == '0);
                    if (n_mask == '0) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_blk   <= n_blk;
        r_step  <= n_step;
        r_mask  <= n_mask;
        r_nb_in <= n_nb_in;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_oz    <= n_oz;
        r_oface <= n_oface;
        r_oblk  <= n_oblk;
        r_olast <= n_olast;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.face_x     = r_ox;
    assign o_out.face_y     = r_oy;
    assign o_out.face_z     = r_oz;
    assign o_out.face       = r_oface;
    assign o_out.face_block = ID_W'(r_oblk);
    assign o_out.last       = r_olast;

endmodule

/* design/voxel_face_culling_top.sv */
`timescale 1ns / 1ps
// Write beat: stored if inside the extents. Mesh beat on a filled cell: up to 7 grid
// reads (center plus in-grid neighbors, one per cycle on the single-port grid memory),
// then one beat per face taken, held while the output stalls; next beat taken once all
// faces are out. Mesh on an empty cell: center read only; outside: taken and dropped.
// Reset (synchronous, active low) sets extents to 16 and clears all 4096 grid cells,
// during which no beat is taken; register writes are taken throughout.
`include "voxel_face_culling_top_assert.svh"
module voxel_face_culling_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    vfc_in_if.sink                      i_in,
    vfc_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vfc_pkg::PADDR_W-1:0] paddr,
    input  logic [vfc_pkg::PDATA_W-1:0] pwdata,
    output logic [vfc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import vfc_pkg::*;

    t_cfg cfg;

    vfc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vfc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    `VFC_CHECK_NOW(a_clear_blocks_input, $past(!i_rst_n), !i_in.ready)
    `VFC_CHECK_NOW(a_busy_while_faces_left, o_out.valid && !o_out.last, !i_in.ready)
    `VFC_CHECK_NEXT(a_emit_continues, o_out.valid && o_out.ready && !o_out.last, o_out.valid)
    `VFC_CHECK_NOW(a_face_sane, o_out.valid, (o_out.face < 3'd6) && (o_out.face_block != '0))

endmodule

/* verif/voxel_face_culling_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for voxel_face_culling_top: grid writes and face meshing,
// checked against a local grid model. Depends on vfc_pkg, vfc_if and the top level.
module voxel_face_culling_top_tb;
    import vfc_pkg::*;

    localparam int       WATCHDOG_LIMIT = 20000;
    localparam int       SETTLE_CYCLES  = 24;
    localparam t_reg_idx REG_UNUSED     = 2'd3;

    typedef struct packed {
        t_pos  x;
        t_pos  y;
        t_pos  z;
        t_face face;
        t_bid  blk;
        logic  last;
    } face_beat_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    vfc_in_if  cmd_if ();
    vfc_out_if face_if ();

    t_bid        grid_ids [CELL_COUNT];
    t_size       size_x_reg;
    t_size       size_y_reg;
    t_size       size_z_reg;
    face_beat_t  pending_faces [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          traffic_gaps = 1'b1;

    voxel_face_culling_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (face_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic int axis_limit(t_size sz, int dim);
        return (int'(sz) < dim) ? int'(sz) : dim;
    endfunction

    function automatic bit cell_in_use(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 &&
               x < axis_limit(size_x_reg, DIM_X) &&
               y < axis_limit(size_y_reg, DIM_Y) &&
               z < axis_limit(size_z_reg, DIM_Z);
    endfunction

    function automatic int grid_addr(int x, int y, int z);
        return (y * DIM_X + x) * DIM_Z + z;
    endfunction

    function automatic bit occupied(int x, int y, int z);
        if (!cell_in_use(x, y, z)) begin
            return 1'b0;
        end
        return grid_ids[grid_addr(x, y, z)] != '0;
    endfunction

    function automatic void apply_command(logic op, t_pos px, t_pos py, t_pos pz, t_bid id);
        int         dx [6] = '{-1, 1, 0, 0, 0, 0};
        int         dy [6] = '{0, 0, 0, 0, 1, -1};
        int         dz [6] = '{0, 0, -1, 1, 0, 0};
        t_face      codes [6] = '{FACE_NX, FACE_PX, FACE_NZ, FACE_PZ, FACE_PY, FACE_NY};
        face_beat_t found [$];
        face_beat_t beat;
        int         x;
        int         y;
        int         z;
        t_bid       blk;
        x = int'(px);
        y = int'(py);
        z = int'(pz);
        if (!cell_in_use(x, y, z)) begin
            return;
        end
        if (op == OP_WRITE) begin
            grid_ids[grid_addr(x, y, z)] = t_bid'(id);
            return;
        end
        blk = grid_ids[grid_addr(x, y, z)];
        if (blk == '0) begin
            return;
        end
        for (int k = 0; k < 6; k++) begin
            if (!occupied(x + dx[k], y + dy[k], z + dz[k])) begin
                beat.x    = px;
                beat.y    = py;
                beat.z    = pz;
                beat.face = codes[k];
                beat.blk  = blk;
                beat.last = 1'b0;
                found.push_back(beat);
            end
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i]) begin
            pending_faces.push_back(found[i]);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        face_beat_t want;
        if (i_rst_n && face_if.valid && face_if.ready) begin
            if (pending_faces.size() == 0) begin
                $error("unexpected face beat: x %0d y %0d z %0d face %0d",
                       face_if.face_x, face_if.face_y, face_if.face_z, face_if.face);
                error_count++;
            end else begin
                want = pending_faces.pop_front();
                check_field("face_x", want.x, face_if.face_x);
                check_field("face_y", want.y, face_if.face_y);
                check_field("face_z", want.z, face_if.face_z);
                check_field("face", want.face, face_if.face);
                check_field("face_block", want.blk, face_if.face_block);
                check_field("last", want.last, face_if.last);
            end
        end
    end

    always @(negedge i_clk) begin
        face_if.ready <= !(traffic_gaps && $urandom_range(99) < 13);
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (face_if.valid && face_if.ready) ||
            (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_cmd(input logic op, input int x, input int y, input int z,
                            input int id);
        if (traffic_gaps && $urandom_range(99) < 13) begin
            cmd_if.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < 30);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.op       <= op;
        cmd_if.pos_x    <= t_pos'(x);
        cmd_if.pos_y    <= t_pos'(y);
        cmd_if.pos_z    <= t_pos'(z);
        cmd_if.block_id <= 8'(id);
        do @(posedge i_clk); while (!cmd_if.ready);
        apply_command(op, t_pos'(x), t_pos'(y), t_pos'(z), t_bid'(id));
        @(negedge i_clk);
    endtask

    task automatic await_idle();
        cmd_if.valid <= 1'b0;
        while (pending_faces.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= {PDATA_W'($urandom) & ~PDATA_W'(32'h1F)} | PDATA_W'(value & 32'h1F);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_SIZE_X: size_x_reg = pwdata[SIZE_W-1:0];
            REG_SIZE_Y: size_y_reg = pwdata[SIZE_W-1:0];
            REG_SIZE_Z: size_z_reg = pwdata[SIZE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_extents(input int sx, input int sy, input int sz);
        await_idle();
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        apb_release();
    endtask

    task automatic test_single_block();
        send_cmd(OP_MESH, 0, 0, 0, 0);
        send_cmd(OP_WRITE, 0, 0, 0, 255);
        send_cmd(OP_MESH, 0, 0, 0, 0);
        send_cmd(OP_WRITE, 15, 15, 15, 1);
        send_cmd(OP_MESH, 15, 15, 15, 0);
        send_cmd(OP_WRITE, 15, 0, 15, 8'h80);
        send_cmd(OP_MESH, 15, 0, 15, 8'hFF);
    endtask

    task automatic test_buried_cell();
        send_cmd(OP_WRITE, 5, 6, 7, 8'h5A);
        send_cmd(OP_WRITE, 4, 6, 7, 8'hA5);
        send_cmd(OP_WRITE, 6, 6, 7, 3);
        send_cmd(OP_WRITE, 5, 6, 6, 4);
        send_cmd(OP_WRITE, 5, 6, 8, 5);
        send_cmd(OP_WRITE, 5, 7, 7, 6);
        send_cmd(OP_WRITE, 5, 5, 7, 7);
        send_cmd(OP_MESH, 5, 6, 7, 0);
        send_cmd(OP_MESH, 4, 6, 7, 0);
        send_cmd(OP_WRITE, 5, 6, 7, 0);
        send_cmd(OP_MESH, 4, 6, 7, 0);
    endtask

    task automatic test_extents();
        set_extents(0, 16, 16);
        send_cmd(OP_MESH, 0, 0, 0, 0);
        set_extents(4, 31, 1);
        send_cmd(OP_WRITE, 3, 1, 0, 9);
        send_cmd(OP_WRITE, 4, 1, 0, 10);
        send_cmd(OP_MESH, 3, 1, 0, 0);
        set_extents(16, 31, 1);
        send_cmd(OP_WRITE, 4, 1, 0, 10);
        send_cmd(OP_MESH, 3, 1, 0, 0);
        await_idle();
        write_reg(REG_UNUSED, 0);
        apb_release();
        send_cmd(OP_MESH, 3, 1, 0, 0);
        set_extents(1, 1, 1);
        send_cmd(OP_MESH, 0, 0, 0, 0);
        send_cmd(OP_MESH, 1, 0, 0, 0);
    endtask

    task automatic run_cluster_burst(input int n_items);
        int   lim_x;
        int   lim_y;
        int   lim_z;
        int   ox;
        int   oy;
        int   oz;
        int   x;
        int   y;
        int   z;
        int   id;
        int   roll;
        logic op;
        lim_x = axis_limit(size_x_reg, DIM_X);
        lim_y = axis_limit(size_y_reg, DIM_Y);
        lim_z = axis_limit(size_z_reg, DIM_Z);
        ox    = 0;
        oy    = 0;
        oz    = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 16 == 0) begin
                ox = $urandom_range(lim_x - 1);
                oy = $urandom_range(lim_y - 1);
                oz = $urandom_range(lim_z - 1);
            end
            if ($urandom_range(99) < 10) begin
                x = $urandom_range(15);
                y = $urandom_range(15);
                z = $urandom_range(15);
            end else begin
                x = (ox + $urandom_range(2) > 15) ? 15 : ox + $urandom_range(2);
                y = (oy + $urandom_range(2) > 15) ? 15 : oy + $urandom_range(2);
                z = (oz + $urandom_range(2) > 15) ? 15 : oz + $urandom_range(2);
            end
            op   = ($urandom_range(99) < 55) ? OP_WRITE : OP_MESH;
            roll = $urandom_range(99);
            if (roll < 15) begin
                id = 0;
            end else if (roll < 20) begin
                id = 255;
            end else begin
                id = $urandom_range(255, 1);
            end
            send_cmd(op, x, y, z, id);
        end
    endtask

    task automatic test_random_traffic();
        set_extents(16, 16, 16);
        run_cluster_burst(55);
        set_extents($urandom_range(16, 1), $urandom_range(16, 1), $urandom_range(16, 1));
        run_cluster_burst(55);
        traffic_gaps = 1'b0;
        set_extents(16, 16, 16);
        run_cluster_burst(55);
        traffic_gaps = 1'b1;
        set_extents(2, 31, 3);
        run_cluster_burst(55);
        set_extents(31, 1, 16);
        run_cluster_burst(55);
        set_extents($urandom_range(31, 17), $urandom_range(16, 1), $urandom_range(31, 17));
        run_cluster_burst(55);
        set_extents(16, 16, 16);
        run_cluster_burst(55);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cmd_if.valid    = 1'b0;
        cmd_if.op       = OP_WRITE;
        cmd_if.pos_x    = '0;
        cmd_if.pos_y    = '0;
        cmd_if.pos_z    = '0;
        cmd_if.block_id = '0;
        face_if.ready   = 1'b0;
        size_x_reg      = SIZE_RESET;
        size_y_reg      = SIZE_RESET;
        size_z_reg      = SIZE_RESET;
        foreach (grid_ids[i]) begin
            grid_ids[i] = '0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_block();
        test_buried_cell();
        test_extents();
        test_random_traffic();

        await_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/vfc_pkg.sv
design/vfc_if.sv
design/vfc_cfg_regs.sv
design/vfc_core.sv
design/voxel_face_culling_top.sv
verif/voxel_face_culling_top_tb.sv
